// File: hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, page entry layout and sequencer types for the buddy
// page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int PAGE_ORDER   = 12;
   localparam int REGION_ORDER = 20;
   localparam int PG_W         = REGION_ORDER - PAGE_ORDER;
   localparam int NPAGES       = 1 << PG_W;
   localparam int NLEVELS      = PG_W + 1;
   localparam int LINK_W       = PG_W + 1;
   localparam int LVL_W        = $clog2(NLEVELS + 1);
   localparam int ORD_W        = 5;
   localparam int OFF_W        = 20;
   localparam int REQ_W        = 21;

   typedef logic [LINK_W-1:0] link_type;
   typedef logic [PG_W-1:0]   page_type;
   typedef logic [LVL_W-1:0]  lvl_type;

   localparam link_type NIL = LINK_W'(NPAGES);

   typedef struct packed {
      logic [ORD_W-1:0] ord;
      logic             free;
      link_type         nxt;
      link_type         prv;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // one memory access per cycle: read at addr always, write when we
   typedef struct packed {
      logic      we;
      page_type  addr;
      entry_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic             ok;
      logic [OFF_W-1:0] offset;
      logic [ORD_W-1:0] order;
   } result_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_A_SRCH, S_POP_D, S_POPN_WR, S_POPP_RD, S_POPP_WR,
      S_SPLIT, S_H_RD, S_H_WR, S_FIN_RD, S_FIN_WR, S_F_RD, S_F_CHK,
      S_M_CHK, S_M_B, S_M_QWR, S_M_N, S_M_NWR, S_M_BW, S_M_PRD, S_M_PWR,
      S_P_RD, S_P_WR, S_DONE
   } state_type;

   function automatic logic link_ok(link_type l);
      return ~l[PG_W];
   endfunction

   function automatic logic [ORD_W-1:0] lvl_to_ord(lvl_type l);
      return ORD_W'(l) + ORD_W'(PAGE_ORDER);
   endfunction

endpackage

// File: hdl/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// binary buddy allocator over 256 pages of 4 KiB with per-order free lists
// ----------------------------------------------------------------------------
// after reset a clearing pass sweeps all 256 page table entries, no item taken
// allocate pops the head block, fixes its successor, then splits down one order at
// a time, pushing each right half; a refused request goes straight to the result
// free checks for a double free, merges with free buddies order by order, then
// pushes the block; one item at a time, ram paced
// result sits in an output register, the next item is taken while it waits; sync reset
module buddy_page_allocator_top
   import bpa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [REQ_W-1:0] req_request_bytes,
   input  logic [OFF_W-1:0] req_free_offset,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_ok,
   output logic [OFF_W-1:0] rsp_block_offset,
   output logic [ORD_W-1:0] rsp_block_order
);

   mem_req_type mem_req;
   logic [ENTRY_W-1:0] mem_rdata;
   logic        done_valid;
   logic        done_ready;
   result_type  done_res;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   // page table: order, free flag and list links per page
   bpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NPAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.addr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.addr),
      .rd_data (mem_rdata)
   );

   bpa_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .mem_req           (mem_req),
      .mem_rdata         (entry_type'(mem_rdata)),
      .done_valid        (done_valid),
      .done_ready        (done_ready),
      .done_res          (done_res)
   );

   // output register: loads when empty or being drained
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_block_offset = rsp_ff.offset;
   assign rsp_block_order  = rsp_ff.order;

endmodule

// File: hdl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// allocate / free sequencer: free list heads, split and merge walks, one
// page table access per cycle
// ----------------------------------------------------------------------------
module bpa_seq
   import bpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  logic [OFF_W-1:0]    req_free_offset,
   output mem_req_type         mem_req,
   input  entry_type           mem_rdata,
   output logic                done_valid,
   input  logic                done_ready,
   output result_type          done_res
);

   state_type  state_ff, state_in;
   link_type   head_ff [NLEVELS];
   link_type   head_in [NLEVELS];
   page_type   clr_ff, clr_in;
   page_type   p_ff, p_in;
   page_type   b_ff, b_in;
   page_type   lk_ff, lk_in;
   lvl_type    lvl_ff, lvl_in;
   lvl_type    r_ff, r_in;
   link_type   n_ff, n_in;
   link_type   q_ff, q_in;
   link_type   h_ff, h_in;
   logic [ORD_W-1:0] bord_ff, bord_in;
   logic       alloc_ff, alloc_in;
   result_type res_ff, res_in;

   lvl_type    enc_r;
   lvl_type    srch_l;
   logic       srch_hit;
   lvl_type    lm1;
   entry_type  d;

   // size to order: count the orders that are too small
   always_comb begin
      enc_r = '0;
      for (int i = 0; i < NLEVELS; i++) begin
         if ({43'd0, req_request_bytes} > (64'd1 << (i + PAGE_ORDER))) begin
            enc_r = enc_r + lvl_type'(1);
         end
      end
   end

   // first non-empty list at or above r
   always_comb begin
      srch_l   = '0;
      srch_hit = 1'b0;
      for (int i = NLEVELS - 1; i >= 0; i--) begin
         if (LVL_W'(i) >= r_ff && link_ok(head_ff[i])) begin
            srch_l   = LVL_W'(i);
            srch_hit = 1'b1;
         end
      end
   end

   assign d   = mem_rdata;
   assign lm1 = lvl_ff - lvl_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         for (int i = 0; i < NLEVELS; i++) begin
            head_ff[i] <= (i == NLEVELS - 1) ? link_type'(0) : NIL;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
      end
      p_ff     <= p_in;
      b_ff     <= b_in;
      lk_ff    <= lk_in;
      lvl_ff   <= lvl_in;
      r_ff     <= r_in;
      n_ff     <= n_in;
      q_ff     <= q_in;
      h_ff     <= h_in;
      bord_ff  <= bord_in;
      alloc_ff <= alloc_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      head_in   = head_ff;
      p_in      = p_ff;
      b_in      = b_ff;
      lk_in     = lk_ff;
      lvl_in    = lvl_ff;
      r_in      = r_ff;
      n_in      = n_ff;
      q_in      = q_ff;
      h_in      = h_ff;
      bord_in   = bord_ff;
      alloc_in  = alloc_ff;
      res_in    = res_ff;
      mem_req   = '0;
      req_ready = 1'b0;
      done_valid = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = clr_ff;
            mem_req.wdata.nxt = NIL;
            mem_req.wdata.prv = NIL;
            if (clr_ff == '0) begin
               mem_req.wdata.ord  = ORD_W'(REGION_ORDER);
               mem_req.wdata.free = 1'b1;
            end else begin
               mem_req.wdata.ord  = ORD_W'(PAGE_ORDER);
               mem_req.wdata.free = 1'b0;
            end
            clr_in = clr_ff + page_type'(1);
            if (clr_ff == page_type'(NPAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_kind) begin
                  r_in     = enc_r;
                  alloc_in = 1'b1;
                  state_in = S_A_SRCH;
               end else begin
                  p_in     = req_free_offset[PAGE_ORDER +: PG_W];
                  alloc_in = 1'b0;
                  state_in = S_F_RD;
               end
            end
         end
         S_A_SRCH: begin
            if (r_ff >= LVL_W'(NLEVELS) || !srch_hit) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               lvl_in       = srch_l;
               p_in         = head_ff[srch_l][PG_W-1:0];
               mem_req.addr = head_ff[srch_l][PG_W-1:0];
               state_in     = S_POP_D;
            end
         end
         S_POP_D: begin
            n_in             = d.nxt;
            head_in[lvl_ff]  = d.nxt;
            if (link_ok(d.nxt)) begin
               mem_req.addr = d.nxt[PG_W-1:0];
               state_in     = S_POPN_WR;
            end else begin
               state_in = S_POPP_RD;
            end
         end
         S_POPN_WR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = n_ff[PG_W-1:0];
            mem_req.wdata     = d;
            mem_req.wdata.prv = NIL;
            state_in          = S_POPP_RD;
         end
         S_POPP_RD: begin
            mem_req.addr = p_ff;
            state_in     = S_POPP_WR;
         end
         S_POPP_WR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = p_ff;
            mem_req.wdata     = d;
            mem_req.wdata.nxt = NIL;
            mem_req.wdata.prv = NIL;
            state_in          = S_SPLIT;
         end
         S_SPLIT: begin
            if (lvl_ff > r_ff) begin
               // right half goes onto the list one order down
               b_in               = p_ff + (page_type'(1) << lm1);
               mem_req.we         = 1'b1;
               mem_req.addr       = b_in;
               mem_req.wdata.ord  = lvl_to_ord(lm1);
               mem_req.wdata.free = 1'b1;
               mem_req.wdata.nxt  = head_ff[lm1];
               mem_req.wdata.prv  = NIL;
               h_in               = head_ff[lm1];
               head_in[lm1]       = {1'b0, b_in};
               lk_in              = b_in;
               lvl_in             = lm1;
               if (link_ok(head_ff[lm1])) begin
                  state_in = S_H_RD;
               end
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_H_RD: begin
            mem_req.addr = h_ff[PG_W-1:0];
            state_in     = S_H_WR;
         end
         S_H_WR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = h_ff[PG_W-1:0];
            mem_req.wdata     = d;
            mem_req.wdata.prv = {1'b0, lk_ff};
            state_in          = alloc_ff ? S_SPLIT : S_DONE;
         end
         S_FIN_RD: begin
            mem_req.addr = p_ff;
            state_in     = S_FIN_WR;
         end
         S_FIN_WR: begin
            mem_req.we         = 1'b1;
            mem_req.addr       = p_ff;
            mem_req.wdata      = d;
            mem_req.wdata.ord  = lvl_to_ord(r_ff);
            mem_req.wdata.free = 1'b0;
            res_in.ok          = 1'b1;
            res_in.offset      = OFF_W'({p_ff, {PAGE_ORDER{1'b0}}});
            res_in.order       = lvl_to_ord(r_ff);
            state_in           = S_DONE;
         end
         S_F_RD: begin
            mem_req.addr = p_ff;
            state_in     = S_F_CHK;
         end
         S_F_CHK: begin
            if (d.free) begin
               // double free
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               mem_req.we         = 1'b1;
               mem_req.addr       = p_ff;
               mem_req.wdata      = d;
               mem_req.wdata.free = 1'b1;
               if (d.ord < ORD_W'(PAGE_ORDER)) begin
                  lvl_in = '0;
               end else if (d.ord > ORD_W'(REGION_ORDER)) begin
                  lvl_in = LVL_W'(NLEVELS - 1);
               end else begin
                  lvl_in = LVL_W'(d.ord - ORD_W'(PAGE_ORDER));
               end
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            if (lvl_ff < LVL_W'(NLEVELS - 1)) begin
               b_in         = p_ff ^ (page_type'(1) << lvl_ff);
               mem_req.addr = b_in;
               state_in     = S_M_B;
            end else begin
               state_in = S_P_RD;
            end
         end
         S_M_B: begin
            if (!d.free || d.ord != lvl_to_ord(lvl_ff)) begin
               state_in = S_P_RD;
            end else begin
               n_in    = d.nxt;
               q_in    = d.prv;
               bord_in = d.ord;
               if (link_ok(d.prv)) begin
                  mem_req.addr = d.prv[PG_W-1:0];
                  state_in     = S_M_QWR;
               end else begin
                  if (head_ff[lvl_ff] == {1'b0, b_ff}) begin
                     head_in[lvl_ff] = d.nxt;
                  end
                  state_in = S_M_N;
               end
            end
         end
         S_M_QWR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = q_ff[PG_W-1:0];
            mem_req.wdata     = d;
            mem_req.wdata.nxt = n_ff;
            state_in          = S_M_N;
         end
         S_M_N: begin
            if (link_ok(n_ff)) begin
               mem_req.addr = n_ff[PG_W-1:0];
               state_in     = S_M_NWR;
            end else begin
               state_in = S_M_BW;
            end
         end
         S_M_NWR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = n_ff[PG_W-1:0];
            mem_req.wdata     = d;
            mem_req.wdata.prv = q_ff;
            state_in          = S_M_BW;
         end
         S_M_BW: begin
            mem_req.we         = 1'b1;
            mem_req.addr       = b_ff;
            mem_req.wdata.ord  = bord_ff;
            mem_req.wdata.free = 1'b0;
            mem_req.wdata.nxt  = NIL;
            mem_req.wdata.prv  = NIL;
            if (b_ff < p_ff) begin
               p_in = b_ff;
            end
            lvl_in   = lvl_ff + lvl_type'(1);
            state_in = S_M_PRD;
         end
         S_M_PRD: begin
            mem_req.addr = p_ff;
            state_in     = S_M_PWR;
         end
         S_M_PWR: begin
            mem_req.we         = 1'b1;
            mem_req.addr       = p_ff;
            mem_req.wdata      = d;
            mem_req.wdata.free = 1'b1;
            mem_req.wdata.ord  = lvl_to_ord(lvl_ff);
            state_in           = S_M_CHK;
         end
         S_P_RD: begin
            mem_req.addr = p_ff;
            state_in     = S_P_WR;
         end
         S_P_WR: begin
            mem_req.we        = 1'b1;
            mem_req.addr      = p_ff;
            mem_req.wdata     = d;
            mem_req.wdata.nxt = head_ff[lvl_ff];
            mem_req.wdata.prv = NIL;
            h_in              = head_ff[lvl_ff];
            head_in[lvl_ff]   = {1'b0, p_ff};
            lk_in             = p_ff;
            res_in.ok         = 1'b1;
            res_in.offset     = OFF_W'({p_ff, {PAGE_ORDER{1'b0}}});
            res_in.order      = lvl_to_ord(lvl_ff);
            state_in          = link_ok(head_ff[lvl_ff]) ? S_H_RD : S_DONE;
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign done_res = res_ff;

endmodule

// File: dv/buddy_page_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_top_tb
// drives allocate and free items into the buddy allocator, keeps a shadow
// page table with per-order free lists and checks every result in order
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_tb
   import bpa_pkg::*;
();

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct {
      logic             kind;
      logic [REQ_W-1:0] bytes;
      logic [OFF_W-1:0] offset;
   } alloc_item_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_kind;
   logic [REQ_W-1:0] req_request_bytes;
   logic [OFF_W-1:0] req_free_offset;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_ok;
   logic [OFF_W-1:0] rsp_block_offset;
   logic [ORD_W-1:0] rsp_block_order;

   buddy_page_allocator_top DUT (.*);

   // shadow of the allocator state
   logic [ORD_W-1:0] shadow_order [NPAGES];
   logic             shadow_free  [NPAGES];
   int unsigned      shadow_next  [NPAGES];
   int unsigned      shadow_prev  [NPAGES];
   int unsigned      shadow_head  [NLEVELS];

   alloc_item_type pending_items[$];
   result_type     expected_results[$];
   int unsigned    live_blocks[$];  // byte offsets handed out and not yet freed
   bit             any_failure;
   bit             stimulus_done;

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   task automatic shadow_reset();
      for (int i = 0; i < NPAGES; i++) begin
         shadow_order[i] = ORD_W'(PAGE_ORDER);
         shadow_free[i]  = 1'b0;
         shadow_next[i]  = NPAGES;
         shadow_prev[i]  = NPAGES;
      end
      for (int l = 0; l < NLEVELS; l++) shadow_head[l] = NPAGES;
      shadow_order[0] = ORD_W'(REGION_ORDER);
      shadow_free[0] = 1'b1;
      shadow_head[NLEVELS-1] = 0;
   endtask

   function automatic void list_push(int unsigned lvl, int unsigned p);
      int unsigned h;
      h = shadow_head[lvl];
      shadow_next[p] = h;
      shadow_prev[p] = NPAGES;
      if (h < NPAGES) shadow_prev[h] = p;
      shadow_head[lvl] = p;
   endfunction

   function automatic void list_unlink(int unsigned lvl, int unsigned p);
      int unsigned n, q;
      n = shadow_next[p];
      q = shadow_prev[p];
      if (q < NPAGES) shadow_next[q] = n;
      else if (shadow_head[lvl] == p) shadow_head[lvl] = n;
      if (n < NPAGES) shadow_prev[n] = q;
      shadow_next[p] = NPAGES;
      shadow_prev[p] = NPAGES;
   endfunction

   // computes the allocator's answer to one item and updates the shadow
   function automatic result_type predict_allocator(alloc_item_type it);
      result_type  res;
      int unsigned r, lvl, p, b, n, o;
      res = '0;
      if (it.kind == KIND_ALLOC) begin
         r = 0;
         while (r < NLEVELS && (longint'(1) << (r + PAGE_ORDER)) < longint'(it.bytes)) r++;
         if (r >= NLEVELS) return res;
         lvl = r;
         while (lvl < NLEVELS && shadow_head[lvl] >= NPAGES) lvl++;
         if (lvl >= NLEVELS) return res;
         p = shadow_head[lvl];
         n = shadow_next[p];
         shadow_head[lvl] = n;
         if (n < NPAGES) shadow_prev[n] = NPAGES;
         shadow_next[p] = NPAGES;
         shadow_prev[p] = NPAGES;
         while (lvl > r) begin
            lvl--;
            b = (p + (1 << lvl)) % NPAGES;
            shadow_order[b] = ORD_W'(lvl + PAGE_ORDER);
            shadow_free[b] = 1'b1;
            list_push(lvl, b);
         end
         shadow_order[p] = ORD_W'(r + PAGE_ORDER);
         shadow_free[p] = 1'b0;
         res.ok = 1'b1;
         res.offset = OFF_W'(p << PAGE_ORDER);
         res.order = ORD_W'(r + PAGE_ORDER);
      end else begin
         p = (it.offset >> PAGE_ORDER) % NPAGES;
         if (shadow_free[p]) return res;
         shadow_free[p] = 1'b1;
         o = shadow_order[p];
         if (o < PAGE_ORDER) lvl = 0;
         else if (o > REGION_ORDER) lvl = NLEVELS - 1;
         else lvl = o - PAGE_ORDER;
         while (lvl < NLEVELS - 1) begin
            b = (p ^ (1 << lvl)) % NPAGES;
            if (!shadow_free[b] || shadow_order[b] != lvl + PAGE_ORDER) break;
            list_unlink(lvl, b);
            shadow_free[b] = 1'b0;
            if (b < p) p = b;
            shadow_free[p] = 1'b1;
            lvl++;
            shadow_order[p] = ORD_W'(lvl + PAGE_ORDER);
         end
         list_push(lvl, p);
         res.ok = 1'b1;
         res.offset = OFF_W'(p << PAGE_ORDER);
         res.order = ORD_W'(lvl + PAGE_ORDER);
      end
      return res;
   endfunction

   task automatic queue_alloc(int unsigned nbytes);
      alloc_item_type it;
      it.kind = KIND_ALLOC;
      it.bytes = REQ_W'(nbytes);
      it.offset = OFF_W'($urandom);  // ignored on allocate, still toggled
      pending_items.push_back(it);
   endtask

   task automatic queue_free(int unsigned off);
      alloc_item_type it;
      it.kind = KIND_FREE;
      it.bytes = REQ_W'($urandom);
      it.offset = OFF_W'(off);
      pending_items.push_back(it);
   endtask

   // random sizes weighted toward small blocks so the table stays busy
   function automatic int unsigned random_size();
      int unsigned ord;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 2097151);
         1: return 0;
         default: begin
            ord = $urandom_range(PAGE_ORDER, PAGE_ORDER + 4);
            return $urandom_range((1 << (ord - 1)) + 1, 1 << ord);
         end
      endcase
   endfunction

   // stimulus: the shadow tracks granted blocks so frees are mostly legal
   initial begin
      alloc_item_type it;
      result_type     r;
      int unsigned    idx;
      shadow_reset();
      // directed part
      queue_alloc(0);                      // zero size gets a single page
      queue_alloc(1 << REGION_ORDER);      // whole region while split: refused
      queue_alloc((1 << REGION_ORDER) + 1);// oversize
      queue_alloc(2097151);                // maximum field value
      queue_free(0);                       // frees page 0, merges up
      queue_alloc(1 << REGION_ORDER);      // whole region granted
      queue_alloc(1);                      // no free block left
      queue_free(20'hFFFFF);               // free of an interior page
      queue_free(0);                       // merges back to the full region
      queue_free(0);                       // double free
      queue_alloc(4097);
      queue_alloc(4096);
      queue_alloc(1 << 19);
      queue_free(20'h81FFF);               // interior page, low bits ignored
      queue_free(20'h02000);
      queue_free(20'h00000);
      queue_free(20'h01000);
      foreach (pending_items[i]) begin
         r = predict_allocator(pending_items[i]);
         expected_results.push_back(r);
      end
      // shadow now holds the state after the directed items
      // random part: predict as we go and track live blocks
      for (int n = 0; n < 1600; n++) begin
         if (live_blocks.size() == 0 || $urandom_range(0, 99) < 52) begin
            it.kind = KIND_ALLOC;
            it.bytes = REQ_W'(random_size());
            it.offset = OFF_W'($urandom);
         end else begin
            it.kind = KIND_FREE;
            it.bytes = REQ_W'($urandom);
            if ($urandom_range(0, 19) == 0) begin
               it.offset = OFF_W'($urandom);  // noise: interior or double free
            end else begin
               idx = $urandom_range(0, live_blocks.size() - 1);
               it.offset = OFF_W'(live_blocks[idx] | $urandom_range(0, 4095));
               live_blocks.delete(idx);
            end
         end
         r = predict_allocator(it);
         if (it.kind == KIND_ALLOC && r.ok) live_blocks.push_back(r.offset);
         pending_items.push_back(it);
         expected_results.push_back(r);
      end
      stimulus_done = 1'b1;
   end

   // driver: bursts of back-to-back items with random gaps between them
   int unsigned burst_left;
   int unsigned gap_left;
   alloc_item_type drive_item;
   logic req_ready_seen;

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_ALLOC;
      req_request_bytes = '0;
      req_free_offset = '0;
      rsp_ready = 1'b0;
      burst_left = 0;
      gap_left = 0;
      any_failure = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_seen) begin
            // item went in at the last rising edge
            if (pending_items.size() > 0 && gap_left == 0 && burst_left > 0) begin
               drive_item = pending_items.pop_front();
               req_kind <= drive_item.kind;
               req_request_bytes <= drive_item.bytes;
               req_free_offset <= drive_item.offset;
               burst_left <= burst_left - 1;
            end else begin
               req_valid <= 1'b0;
               gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
            end
         end else if (!req_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0 && stimulus_done) begin
               drive_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_kind <= drive_item.kind;
               req_request_bytes <= drive_item.bytes;
               req_free_offset <= drive_item.offset;
               burst_left <= $urandom_range(0, 30);
            end
         end
         // receiver stall pattern: long ready runs mixed with stall stretches
         if ($urandom_range(0, 99) < 10) rsp_ready <= ~rsp_ready;
         else if (!rsp_ready && $urandom_range(0, 3) == 0) rsp_ready <= 1'b1;
      end
   end

   // acceptance of the input item as seen at the rising edge
   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready && !reset;
   end

   // monitor: compare each result with the oldest expectation
   result_type exp_res;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: ok=%0d offset=%h order=%0d",
                   rsp_ok, rsp_block_offset, rsp_block_order);
            any_failure = 1'b1;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_ok !== exp_res.ok) begin
               $error("ok expected %0d actual %0d", exp_res.ok, rsp_ok);
               any_failure = 1'b1;
            end
            if (rsp_block_offset !== exp_res.offset) begin
               $error("block_offset expected %h actual %h",
                      exp_res.offset, rsp_block_offset);
               any_failure = 1'b1;
            end
            if (rsp_block_order !== exp_res.order) begin
               $error("block_order expected %0d actual %0d",
                      exp_res.order, rsp_block_order);
               any_failure = 1'b1;
            end
         end
      end
   end

   // end of run: all items sent, all results back, then a short drain
   initial begin
      wait (stimulus_done);
      wait (pending_items.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (!any_failure && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
